// ===== src/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants for the heightmap 3x3 smoothing unit
// Field widths, register map, queue item layout and the reciprocal table
// used to divide by 255 times the neighbour count.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int SAMPLE_W    = 8;
    localparam int SIZE_W      = 11;
    localparam int HEIGHT_W    = 16;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int DIV_W       = 12;
    localparam int PROD_W      = 28;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 21;
    localparam int QUEUE_DEPTH = 4;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_HEIGHT = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic [SIZE_W-1:0]   RST_MAP_WIDTH  = 11'd256;
    localparam logic [SIZE_W-1:0]   RST_MAP_HEIGHT = 11'd256;
    localparam logic [HEIGHT_W-1:0] RST_MAX_HEIGHT = 16'd256;

    // floor(2^28 / (255 * count)) for each count a window can have
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((1 << RECIP_SHIFT) / 255);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((1 << RECIP_SHIFT) / 510);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((1 << RECIP_SHIFT) / 765);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((1 << RECIP_SHIFT) / 1020);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((1 << RECIP_SHIFT) / 1530);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((1 << RECIP_SHIFT) / 2295);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             last;
    } hbs_item_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        unique case (count)
            4'd1:    m = RECIP_1;
            4'd2:    m = RECIP_2;
            4'd3:    m = RECIP_3;
            4'd4:    m = RECIP_4;
            4'd6:    m = RECIP_6;
            4'd9:    m = RECIP_9;
            default: m = RECIP_1;
        endcase
        return m;
    endfunction

    function automatic logic [DIV_W-1:0] divisor_of(input logic [CNT_W-1:0] count);
        return DIV_W'(count) * DIV_W'(255);
    endfunction

endpackage

// ===== src/heightmap_box_smooth_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// heightmap_box_smooth_3x3_unit: edge-normalized 3x3 height smoothing
// Timing: results trail the input stream by one row plus one sample.
// Input: after a sample or a drain tick past the map, s_axis_tready drops while
//   the line-buffer memories are read and rewritten; a drain tick inside the
//   map is taken and dropped without that pause.
// Reset: positions, window, queue and pipeline valids clear; line buffers keep
//   their contents; map_width, map_height and max_height return to 256.
// ----------------------------------------------------------------------------
module heightmap_box_smooth_3x3_unit #(
    parameter int MAX_WIDTH  = hbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hbs_pkg::ADDR_W-1:0]    paddr,
    input  logic [hbs_pkg::DATA_W-1:0]    pwdata,
    output logic [hbs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hbs_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [7:0] sample
    input  logic                          s_axis_tuser,   // [0] op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hbs_pkg::HEIGHT_W-1:0]  m_axis_tdata,   // [15:0] smoothed_height
    output logic                          m_axis_tlast
);
    import hbs_pkg::*;

    logic [SIZE_W-1:0]    map_width_reg;
    logic [SIZE_W-1:0]    map_height_reg;
    logic [HEIGHT_W-1:0]  max_height_reg;
    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic                 restart;

    logic                 push;
    hbs_item_t            push_item;
    logic                 queue_full;
    logic                 pop;
    hbs_item_t            head_item;
    logic                 queue_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];
    assign restart   = cfg_write &&
                       (cfg_index == REG_MAP_WIDTH || cfg_index == REG_MAP_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= RST_MAP_WIDTH;
            map_height_reg <= RST_MAP_HEIGHT;
            max_height_reg <= RST_MAX_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= pwdata[SIZE_W-1:0];
                REG_MAP_HEIGHT: map_height_reg <= pwdata[SIZE_W-1:0];
                REG_MAX_HEIGHT: max_height_reg <= pwdata[HEIGHT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_MAP_WIDTH:  prdata = DATA_W'(map_width_reg);
            REG_MAP_HEIGHT: prdata = DATA_W'(map_height_reg);
            REG_MAX_HEIGHT: prdata = DATA_W'(max_height_reg);
            default:        prdata = '0;
        endcase
    end

    hbs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart),
        .map_width     (map_width_reg),
        .map_height    (map_height_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_item     (push_item),
        .queue_full    (queue_full)
    );

    hbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty)
    );

    hbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_height    (max_height_reg),
        .pop           (pop),
        .head_item     (head_item),
        .queue_empty   (queue_empty),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== src/hbs_queue.sv =====
// ----------------------------------------------------------------------------
// hbs_queue: short FIFO between the window front end and the divide pipeline
// Holds classified window sums so each side can stall on its own.
// ----------------------------------------------------------------------------
module hbs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hbs_pkg::hbs_item_t push_item,
    output logic              full,
    input  logic              pop,
    output hbs_pkg::hbs_item_t head_item,
    output logic              empty
);
    import hbs_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    hbs_item_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               do_push;
    logic               do_pop;

    assign full      = (32'(fill_reg) == 32'(QUEUE_DEPTH));
    assign empty     = (fill_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/hbs_front.sv =====
// ----------------------------------------------------------------------------
// hbs_front: line buffers, 3x3 window and edge classification
// Accepts raw samples and drain ticks, keeps two rows in memory, and emits
// the masked window sum, neighbour count and end-of-map flag per result.
// ----------------------------------------------------------------------------
module hbs_front #(
    parameter int MAX_WIDTH  = hbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [hbs_pkg::SIZE_W-1:0]    map_width,
    input  logic [hbs_pkg::SIZE_W-1:0]    map_height,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hbs_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tuser,
    output logic                          push,
    output hbs_pkg::hbs_item_t            push_item,
    input  logic                          queue_full
);
    import hbs_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WC_W   = $clog2(MAX_WIDTH + 1);
    localparam int HC_W   = $clog2(MAX_HEIGHT + 1);
    localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic                 state_reg;
    logic [COL_W-1:0]     in_col_reg;
    logic [IROW_W-1:0]    in_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic [OROW_W-1:0]    out_row_reg;
    logic                 in_map_reg;
    logic [SAMPLE_W-1:0]  win_reg [9];
    logic [SAMPLE_W-1:0]  win_next [9];

    logic [SAMPLE_W-1:0]  upper_mem  [MAX_WIDTH];
    logic [SAMPLE_W-1:0]  middle_mem [MAX_WIDTH];
    logic [SAMPLE_W-1:0]  upper_rd_reg;
    logic [SAMPLE_W-1:0]  middle_rd_reg;
    logic [SAMPLE_W-1:0]  bot_reg;

    logic [WC_W-1:0]      wc;
    logic [HC_W-1:0]      hc;
    logic                 accept;
    logic                 in_map;
    logic                 accept_work;
    logic                 work;
    logic                 emit;
    logic                 col_wrap;
    logic                 row_first;
    logic                 row_final;
    logic                 col_first;
    logic                 col_final;
    logic [1:0]           rows_n;
    logic [1:0]           cols_n;
    logic [SUM_W-1:0]     sum;
    logic                 keep_row [3];
    logic                 keep_col [3];

    // Clamp map size into the supported range
    always_comb
    begin
        priority if (map_width == '0)
            wc = WC_W'(1);
        else if (32'(map_width) > 32'(MAX_WIDTH))
            wc = WC_W'(MAX_WIDTH);
        else
            wc = WC_W'(map_width);

        priority if (map_height == '0)
            hc = HC_W'(1);
        else if (32'(map_height) > 32'(MAX_HEIGHT))
            hc = HC_W'(MAX_HEIGHT);
        else
            hc = HC_W'(map_height);
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_map        = (32'(in_row_reg) < 32'(hc));
    // a drain tick inside the map is taken and dropped
    assign accept_work   = accept && !(s_axis_tuser == OP_DRAIN && in_map);
    assign work          = (state_reg == ST_WORK);

    // Line buffers: read old contents on each accepted sample or outer drain tick, then rotate middle into upper
    always_ff @(posedge clk)
    begin
        if (accept_work)
        begin
            upper_rd_reg  <= upper_mem[in_col_reg];
            middle_rd_reg <= middle_mem[in_col_reg];
            bot_reg       <= in_map ? s_axis_tdata : '0;
        end
        if (accept_work && in_map)
        begin
            middle_mem[in_col_reg] <= s_axis_tdata;
        end
        if (work && in_map_reg)
        begin
            upper_mem[in_col_reg] <= middle_rd_reg;
        end
    end

    assign emit      = (32'(in_row_reg) >= 32'd2) ||
                       (32'(in_row_reg) == 32'd1 && in_col_reg != '0);
    assign col_wrap  = (32'(in_col_reg) + 32'd1 >= 32'(wc));
    assign row_first = (out_row_reg == '0);
    assign row_final = (32'(out_row_reg) + 32'd1 >= 32'(hc));
    assign col_first = (out_col_reg == '0);
    assign col_final = (32'(out_col_reg) + 32'd1 >= 32'(wc));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]     = win_reg[i*3 + 1];
            win_next[i*3 + 1] = win_reg[i*3 + 2];
        end
        win_next[2] = upper_rd_reg;
        win_next[5] = middle_rd_reg;
        win_next[8] = bot_reg;

        keep_row[0] = !row_first;
        keep_row[1] = 1'b1;
        keep_row[2] = !row_final;
        keep_col[0] = !col_first;
        keep_col[1] = 1'b1;
        keep_col[2] = !col_final;

        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (keep_row[i] && keep_col[j])
                begin
                    sum = sum + SUM_W'(win_next[i*3 + j]);
                end
            end
        end
    end

    assign rows_n = 2'd3 - {1'b0, row_first} - {1'b0, row_final};
    assign cols_n = 2'd3 - {1'b0, col_first} - {1'b0, col_final};

    assign push            = work && emit;
    assign push_item.sum   = sum;
    assign push_item.count = CNT_W'(rows_n) * CNT_W'(cols_n);
    assign push_item.last  = row_final && col_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            in_map_reg  <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_work)
                    begin
                        state_reg  <= ST_WORK;
                        in_map_reg <= in_map;
                    end
                end
                ST_WORK:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            priority if (restart || (push && push_item.last))
            begin
                // back to the start of a frame
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else if (work)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
                if (col_wrap)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
                if (emit)
                begin
                    if (col_final)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ===== src/hbs_back.sv =====
// ----------------------------------------------------------------------------
// hbs_back: scale and normalize pipeline with output register
// Computes floor(sum * max_height / (255 * count)) with a reciprocal
// multiply and one remainder correction, at most one multiply per stage.
// ----------------------------------------------------------------------------
module hbs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hbs_pkg::HEIGHT_W-1:0]  max_height,
    output logic                          pop,
    input  hbs_pkg::hbs_item_t            head_item,
    input  logic                          queue_empty,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hbs_pkg::HEIGHT_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast
);
    import hbs_pkg::*;

    localparam int MUL_W = PROD_W + RECIP_W;

    logic                 adv;

    logic                 v1_reg;
    logic [PROD_W-1:0]    p1_reg;
    logic [RECIP_W-1:0]   m1_reg;
    logic [DIV_W-1:0]     d1_reg;
    logic                 l1_reg;

    logic                 v2_reg;
    logic [PROD_W-1:0]    p2_reg;
    logic [HEIGHT_W-1:0]  q2_reg;
    logic [DIV_W-1:0]     d2_reg;
    logic                 l2_reg;

    logic                 v3_reg;
    logic [PROD_W-1:0]    rem3_reg;
    logic [HEIGHT_W-1:0]  q3_reg;
    logic [DIV_W-1:0]     d3_reg;
    logic                 l3_reg;

    logic                 out_valid_reg;
    logic [HEIGHT_W-1:0]  out_data_reg;
    logic                 out_last_reg;

    logic [MUL_W-1:0]     est_next;
    logic [PROD_W-1:0]    back_next;
    logic                 fix_next;

    // Advance the whole pipe unless the output is held
    assign adv = !out_valid_reg || m_axis_tready;
    assign pop = adv && !queue_empty;

    assign est_next  = MUL_W'(p1_reg) * MUL_W'(m1_reg);
    assign back_next = PROD_W'(q2_reg) * PROD_W'(d2_reg);
    assign fix_next  = (rem3_reg >= PROD_W'(d3_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= PROD_W'(head_item.sum) * PROD_W'(max_height);
            m1_reg <= recip_of(head_item.count);
            d1_reg <= divisor_of(head_item.count);
            l1_reg <= head_item.last;

            p2_reg <= p1_reg;
            q2_reg <= est_next[RECIP_SHIFT +: HEIGHT_W];
            d2_reg <= d1_reg;
            l2_reg <= l1_reg;

            rem3_reg <= p2_reg - back_next;
            q3_reg   <= q2_reg;
            d3_reg   <= d2_reg;
            l3_reg   <= l2_reg;

            out_data_reg <= q3_reg + HEIGHT_W'(fix_next);
            out_last_reg <= l3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= pop;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== src/hbs_checker.sv =====
// ----------------------------------------------------------------------------
// hbs_checker: port-level checks for the heightmap smoothing unit
// Watches the stream and register ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module hbs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [hbs_pkg::ADDR_W-1:0]    paddr,
    input logic [hbs_pkg::DATA_W-1:0]    pwdata,
    input logic [hbs_pkg::DATA_W-1:0]    prdata,
    input logic                          pready,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [hbs_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [hbs_pkg::HEIGHT_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tlast
);
    import hbs_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a raw sample holds off the input while the line buffers are updated
    a_sample_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SAMPLE |=> !s_axis_tready)
        else $error("input ready during line buffer update");

    // no result may be pending when reset lifts
    a_reset_clear: assert property (
        @(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid out of reset");

    // max_height reads back what was just written
    a_max_height_readback: assert property (
        @(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[3:2] == REG_MAX_HEIGHT)
            ##1 (psel && !pwrite && paddr[3:2] == REG_MAX_HEIGHT)
            |-> prdata[HEIGHT_W-1:0] == $past(pwdata[HEIGHT_W-1:0]))
        else $error("max_height readback mismatch");

endmodule

bind heightmap_box_smooth_3x3_unit hbs_checker u_hbs_checker (.*);
